// ===== rtl/rmst_pkg.sv =====
package rmst_pkg;

    // default tree size, a power of two
    localparam int ENTRIES_DEF = 1024;

    // fixed field widths
    localparam int OPC_W  = 1;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 11;
    localparam int RNG_W  = 11;
    localparam int OUT_W  = 12;

    // opcode values
    localparam logic [OPC_W-1:0] OPC_UPDATE = 1'b0;
    localparam logic [OPC_W-1:0] OPC_QUERY  = 1'b1;

    // result for an empty range (-1 in two's complement)
    localparam logic [OUT_W-1:0] NOT_FOUND = {OUT_W{1'b1}};

    // controller to datapath
    typedef struct packed {
        logic clr_en;     // write the reset value at the sweep address
        logic acc_upd;    // update beat taken: write leaf, start at leaf
        logic acc_qry;    // query beat taken: load clamped bounds
        logic upd_read;   // read sibling of the current path node
        logic upd_merge;  // write parent max, move up one level
        logic qry_read;   // read border nodes, step bounds up one level
        logic qry_acc;    // fold read border nodes into the running max
        logic out_load;   // move query result into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;   // sweep is at the last node
        logic upd_root;   // update path reached the root
        logic qry_end;    // query bounds met
        logic out_free;   // output register can take a result
    } sts_t;

endpackage

// ===== rtl/rmst_ctrl.sv =====
module rmst_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           opcode,
    output logic           in_stall,
    output rmst_pkg::cmd_t cmd,
    input  rmst_pkg::sts_t sts
);
    import rmst_pkg::*;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_UPD_RD  = 3'd2;
    localparam logic [2:0] S_UPD_MG  = 3'd3;
    localparam logic [2:0] S_QRY_RD  = 3'd4;
    localparam logic [2:0] S_QRY_ACC = 3'd5;
    localparam logic [2:0] S_QRY_OUT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (opcode == OPC_UPDATE)
                    begin
                        cmd.acc_upd = 1'b1;
                        state_next  = S_UPD_RD;
                    end
                    else
                    begin
                        cmd.acc_qry = 1'b1;
                        state_next  = S_QRY_RD;
                    end
                end
            end
            S_UPD_RD:
            begin
                if (sts.upd_root)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.upd_read = 1'b1;
                    state_next   = S_UPD_MG;
                end
            end
            S_UPD_MG:
            begin
                cmd.upd_merge = 1'b1;
                state_next    = S_UPD_RD;
            end
            S_QRY_RD:
            begin
                if (sts.qry_end)
                begin
                    state_next = S_QRY_OUT;
                end
                else
                begin
                    cmd.qry_read = 1'b1;
                    state_next   = S_QRY_ACC;
                end
            end
            S_QRY_ACC:
            begin
                cmd.qry_acc = 1'b1;
                state_next  = S_QRY_RD;
            end
            S_QRY_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/rmst_datapath.sv =====
module rmst_datapath #(
    parameter int ENTRIES = rmst_pkg::ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rmst_pkg::cmd_t                     cmd,
    output rmst_pkg::sts_t                     sts,
    input  logic [rmst_pkg::IDX_W-1:0]         entry_index,
    input  logic [rmst_pkg::VAL_W-1:0]         new_value,
    input  logic [rmst_pkg::RNG_W-1:0]         range_low,
    input  logic [rmst_pkg::RNG_W-1:0]         range_high,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic signed [rmst_pkg::OUT_W-1:0]  max_value
);
    import rmst_pkg::*;

    localparam int LEVELS = $clog2(ENTRIES);
    localparam int AW     = LEVELS + 1;           // node address
    localparam int LW     = AW + 1;               // query bound, up to 2*ENTRIES
    localparam int NODES  = 2 * ENTRIES;
    localparam int NODE_W = ($clog2(ENTRIES + 1) > VAL_W) ? $clog2(ENTRIES + 1) : VAL_W;

    logic [NODE_W-1:0] mem [NODES];

    logic [AW-1:0]     clr_addr_reg;
    logic [AW-1:0]     pos_reg;        // 1-based heap position on the update path
    logic [NODE_W-1:0] cur_reg;        // value of the node at pos_reg
    logic [LW-1:0]     l_reg;          // 1-based query bounds, half open
    logic [LW-1:0]     r_reg;
    logic              use_a_reg;
    logic              use_b_reg;
    logic [NODE_W-1:0] rd_a_reg;
    logic [NODE_W-1:0] rd_b_reg;
    logic [NODE_W-1:0] best_reg;
    logic              found_reg;
    logic [OUT_W-1:0]  out_val_reg;
    logic              out_valid_reg;

    logic [31:0]       idx_ext;
    logic [LEVELS-1:0] leaf;
    logic [AW-1:0]     leaf_pos;
    logic [LW-1:0]     lo_c;
    logic [LW-1:0]     hi_c;
    logic [NODE_W-1:0] merged;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [NODE_W-1:0] wr_data;
    logic [AW-1:0]     rd_a_addr;
    logic [AW-1:0]     rd_b_addr;
    logic [AW-1:0]     parent_pos;
    logic [LW-1:0]     r_minus2;
    logic [NODE_W-1:0] fold_a;
    logic [NODE_W-1:0] fold_ab;

    // indexes past the last leaf land on the last leaf
    assign idx_ext  = 32'(entry_index);
    assign leaf     = (idx_ext >= 32'(ENTRIES)) ? LEVELS'(ENTRIES - 1) : idx_ext[LEVELS-1:0];
    assign leaf_pos = {1'b1, leaf};

    // query bounds clamped to the leaf count
    assign lo_c = (32'(range_low) >= 32'(ENTRIES)) ? LW'(ENTRIES) : LW'(range_low);
    assign hi_c = (32'(range_high) >= 32'(ENTRIES)) ? LW'(ENTRIES) : LW'(range_high);

    assign merged     = (rd_a_reg > cur_reg) ? rd_a_reg : cur_reg;
    assign parent_pos = pos_reg >> 1;
    assign r_minus2   = r_reg - LW'(2);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = NODE_W'(ENTRIES);
        if (cmd.clr_en)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.acc_upd)
        begin
            wr_en   = 1'b1;
            wr_addr = leaf_pos - AW'(1);
            wr_data = NODE_W'(new_value);
        end
        else if (cmd.upd_merge)
        begin
            wr_en   = 1'b1;
            wr_addr = parent_pos - AW'(1);
            wr_data = merged;
        end
    end

    // port a: sibling on update, left border on query; port b: right border
    assign rd_a_addr = cmd.upd_read ? ((pos_reg ^ AW'(1)) - AW'(1))
                                    : AW'(l_reg - LW'(1));
    assign rd_b_addr = r_minus2[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_comb
    begin
        fold_a  = (use_a_reg && rd_a_reg > best_reg) ? rd_a_reg : best_reg;
        fold_ab = (use_b_reg && rd_b_reg > fold_a) ? rd_b_reg : fold_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            use_a_reg     <= 1'b0;
            use_b_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clr_en)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.acc_qry)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.qry_acc)
            begin
                found_reg <= found_reg | use_a_reg | use_b_reg;
            end
            if (cmd.qry_read)
            begin
                use_a_reg <= l_reg[0];
                use_b_reg <= r_reg[0];
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_upd)
        begin
            pos_reg <= leaf_pos;
            cur_reg <= NODE_W'(new_value);
        end
        else if (cmd.upd_merge)
        begin
            pos_reg <= parent_pos;
            cur_reg <= merged;
        end
        if (cmd.acc_qry)
        begin
            l_reg    <= LW'(ENTRIES) + lo_c;
            r_reg    <= LW'(ENTRIES) + hi_c;
            best_reg <= '0;
        end
        else if (cmd.qry_read)
        begin
            l_reg <= (l_reg + LW'(l_reg[0])) >> 1;
            r_reg <= (r_reg - LW'(r_reg[0])) >> 1;
        end
        else if (cmd.qry_acc)
        begin
            best_reg <= fold_ab;
        end
        if (cmd.out_load)
        begin
            out_val_reg <= found_reg ? OUT_W'(best_reg) : NOT_FOUND;
        end
    end

    assign sts.clr_last = (clr_addr_reg == AW'(NODES - 1));
    assign sts.upd_root = (pos_reg == AW'(1));
    assign sts.qry_end  = (l_reg >= r_reg);
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign max_value = out_val_reg;

endmodule

// ===== rtl/range_max_segment_tree_top.sv =====
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  opcode, entry_index, new_value, range_low, range_high
// out      output     out_valid/out_stall  max_value (one beat per query, none per update)
//
// update: one read-merge pair per tree level
// query: one read-fold pair per level plus one for the root, both border nodes of a level
//   read together through the two memory read ports
// after reset all 2*ENTRIES tree memory nodes are swept to ENTRIES, in_stall held high
// one beat in flight at a time; the output register holds a result under out_stall while
//   the next beat is taken, and a query ending under a full output register waits there
module range_max_segment_tree_top #(
    parameter int ENTRIES = rmst_pkg::ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rmst_pkg::OPC_W-1:0]         opcode,
    input  logic [rmst_pkg::IDX_W-1:0]         entry_index,
    input  logic [rmst_pkg::VAL_W-1:0]         new_value,
    input  logic [rmst_pkg::RNG_W-1:0]         range_low,
    input  logic [rmst_pkg::RNG_W-1:0]         range_high,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [rmst_pkg::OUT_W-1:0]  max_value
);
    import rmst_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing: sweep, beat intake, path walk and border walk
    rmst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    // tree memory, path and bound registers, output register
    rmst_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .entry_index (entry_index),
        .new_value   (new_value),
        .range_low   (range_low),
        .range_high  (range_high),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .max_value   (max_value)
    );

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending beat");

    // no beat is taken while the memory sweep runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !cmd.clr_en)
        else $error("beat taken during memory sweep");

    // one write source into the tree memory per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_en, cmd.acc_upd, cmd.upd_merge}))
        else $error("conflicting tree memory writes");

    // an update never produces a result right after intake
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_upd |=> !cmd.out_load)
        else $error("result loaded after an update");

endmodule
